// File: sv/scanline_background_fetch_scheduler_assert.svh
// assertion macros for the scanline background fetch scheduler
// no dependencies; included by the modules that carry assertions
`ifndef SCANLINE_BACKGROUND_FETCH_SCHEDULER_ASSERT_SVH
`define SCANLINE_BACKGROUND_FETCH_SCHEDULER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SBFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define SBFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sbfs_pkg.sv
// shared types and constants of the scanline background fetch scheduler
// no dependencies; used by the interfaces and all modules
package sbfs_pkg;

  localparam int CYCLE_W    = 11;
  localparam int LINE_W     = 8;
  localparam int REF_IN_W   = 28;
  localparam int REF_W      = 32;
  localparam int STEP_W     = 16;
  localparam int MODE_W     = 3;
  localparam int MSIZE_W    = 5;
  localparam int MOSAIC_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = MSIZE_W + 1 + STEP_W;

  // last line below which the vertical mosaic counter runs
  localparam logic [LINE_W-1:0] MOSAIC_LAST_LINE = LINE_W'(159);

  // background modes
  localparam logic [MODE_W-1:0] MODE_TEXT         = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_MIXED        = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_AFFINE       = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_BITMAP_FIRST = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_BITMAP_LAST  = MODE_W'(5);

  typedef enum logic [1:0] {
    FUNC_WRITE_REF  = 2'd0,
    FUNC_LINE_START = 2'd1,
    FUNC_TICK       = 2'd2
  } sbfs_func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BG_MODE     = 3'd0,
    CFG_ENABLE_MASK = 3'd1,
    CFG_MOSAIC_Y    = 3'd2,
    CFG_MOSAIC_EN   = 3'd3,
    CFG_STEP_B_BG2  = 3'd4,
    CFG_STEP_D_BG2  = 3'd5,
    CFG_STEP_B_BG3  = 3'd6,
    CFG_STEP_D_BG3  = 3'd7
  } sbfs_cfg_idx_e;

  typedef struct packed {
    logic [MODE_W-1:0]        bg_mode;
    logic [3:0]               enable_mask;
    logic [MSIZE_W-1:0]       mosaic_size_y;
    logic [1:0]               mosaic_enable_mask;
    logic signed [STEP_W-1:0] step_b_bg2;
    logic signed [STEP_W-1:0] step_d_bg2;
    logic signed [STEP_W-1:0] step_b_bg3;
    logic signed [STEP_W-1:0] step_d_bg3;
  } sbfs_cfg_t;

  // per-tick schedule decision, without the reference values
  typedef struct packed {
    logic               text_valid;
    logic [1:0]         text_bg;
    logic               affine_valid;
    logic               affine_bg;
    logic               bitmap_valid;
    logic [CYCLE_W-1:0] dot_cycle;
    logic               line_end;
    logic               ref_valid;
    logic               ref_id;
  } sbfs_sched_t;

  // control from the scheduler to the reference unit
  typedef struct packed {
    logic       line_start;
    logic       first_line;
    logic [1:0] advance;
    logic [1:0] use_mosaic;
  } sbfs_ref_ctl_t;

  typedef struct packed {
    logic                    text_valid;
    logic [1:0]              text_bg;
    logic                    affine_valid;
    logic                    affine_bg;
    logic                    bitmap_valid;
    logic [CYCLE_W-1:0]      dot_cycle;
    logic signed [REF_W-1:0] ref_x;
    logic signed [REF_W-1:0] ref_y;
    logic                    line_end;
  } sbfs_result_t;

endpackage

// File: sv/sbfs_item_if.sv
// input item channel of the scanline background fetch scheduler
// depends on sbfs_pkg for field widths
interface sbfs_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           func;
  logic [sbfs_pkg::LINE_W-1:0]          line_number;
  logic                                 ref_bg;
  logic                                 ref_axis;
  logic signed [sbfs_pkg::REF_IN_W-1:0] ref_value;

  modport source (
    output valid, func, line_number, ref_bg, ref_axis, ref_value,
    input  ready
  );
  modport sink (
    input  valid, func, line_number, ref_bg, ref_axis, ref_value,
    output ready
  );
endinterface

// File: sv/sbfs_result_if.sv
// result item channel of the scanline background fetch scheduler
// depends on sbfs_pkg for field widths
interface sbfs_result_if;
  logic                              valid;
  logic                              ready;
  logic                              text_valid;
  logic [1:0]                        text_bg;
  logic                              affine_valid;
  logic                              affine_bg;
  logic                              bitmap_valid;
  logic [sbfs_pkg::CYCLE_W-1:0]      dot_cycle;
  logic signed [sbfs_pkg::REF_W-1:0] ref_x;
  logic signed [sbfs_pkg::REF_W-1:0] ref_y;
  logic                              line_end;

  modport source (
    output valid, text_valid, text_bg, affine_valid, affine_bg, bitmap_valid,
           dot_cycle, ref_x, ref_y, line_end,
    input  ready
  );
  modport sink (
    input  valid, text_valid, text_bg, affine_valid, affine_bg, bitmap_valid,
           dot_cycle, ref_x, ref_y, line_end,
    output ready
  );
endinterface

// File: sv/scanline_background_fetch_scheduler.sv
// Scanline background fetch scheduler: takes one item per clock cycle (reference
// write, line start or dot-cycle tick) while ready is high and returns one result
// per tick from a single registered decode pass. An output register with a skid
// stage behind it keeps input transfers going for one more item while a result
// waits, so the rate holds while results are taken. The user writes configuration
// via cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle; not enforced by the block.
// Depends on sbfs_pkg, sbfs_item_if, sbfs_result_if, sbfs_dot_sched, sbfs_ref_unit.
`include "scanline_background_fetch_scheduler_assert.svh"

module scanline_background_fetch_scheduler #(
  parameter int LINE_CYCLES   = 1232,
  parameter int ACTIVE_CYCLES = 1007
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sbfs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sbfs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  sbfs_item_if.sink                         item_i,
  sbfs_result_if.source                     result_o
);
  import sbfs_pkg::*;

  sbfs_cfg_t     cfg_q;
  sbfs_sched_t   sched;
  sbfs_ref_ctl_t ref_ctl;
  sbfs_result_t  res_new;
  sbfs_result_t  out_q, skid_q;
  logic          out_valid_q, skid_valid_q;

  logic signed [REF_W-1:0] line_x [2];
  logic signed [REF_W-1:0] line_y [2];

  logic       item_xfer, is_write, is_line_start, is_tick;
  logic       out_xfer;
  sbfs_func_e func;

  // input transfer and command decode
  assign item_i.ready  = !skid_valid_q;
  assign item_xfer     = item_i.valid && item_i.ready;
  assign func          = sbfs_func_e'(item_i.func);
  assign is_write      = item_xfer && (func == FUNC_WRITE_REF);
  assign is_line_start = item_xfer && (func == FUNC_LINE_START);
  assign is_tick       = item_xfer && (func == FUNC_TICK);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mosaic_size_y: MSIZE_W'(1), default: '0};
    end else if (cfg_we_i) begin
      case (sbfs_cfg_idx_e'(cfg_idx_i))
        CFG_BG_MODE:     cfg_q.bg_mode            <= cfg_wdata_i[MODE_W-1:0];
        CFG_ENABLE_MASK: cfg_q.enable_mask        <= cfg_wdata_i[3:0];
        CFG_MOSAIC_Y:    cfg_q.mosaic_size_y      <= cfg_wdata_i[MSIZE_W-1:0];
        CFG_MOSAIC_EN:   cfg_q.mosaic_enable_mask <= cfg_wdata_i[1:0];
        CFG_STEP_B_BG2:  cfg_q.step_b_bg2         <= cfg_wdata_i[STEP_W-1:0];
        CFG_STEP_D_BG2:  cfg_q.step_d_bg2         <= cfg_wdata_i[STEP_W-1:0];
        CFG_STEP_B_BG3:  cfg_q.step_b_bg3         <= cfg_wdata_i[STEP_W-1:0];
        CFG_STEP_D_BG3:  cfg_q.step_d_bg3         <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  sbfs_dot_sched #(
    .LINE_CYCLES   (LINE_CYCLES),
    .ACTIVE_CYCLES (ACTIVE_CYCLES)
  ) u_sched (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (is_tick),
    .line_start_i  (is_line_start),
    .line_number_i (item_i.line_number),
    .cfg_i         (cfg_q),
    .sched_o       (sched),
    .ref_ctl_o     (ref_ctl)
  );

  sbfs_ref_unit u_ref (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (is_write),
    .wr_bg_i    (item_i.ref_bg),
    .wr_axis_i  (item_i.ref_axis),
    .wr_value_i (item_i.ref_value),
    .ctl_i      (ref_ctl),
    .cfg_i      (cfg_q),
    .line_x_o   (line_x),
    .line_y_o   (line_y)
  );

  // assemble the result of this tick
  always_comb begin
    res_new              = '0;
    res_new.text_valid   = sched.text_valid;
    res_new.text_bg      = sched.text_bg;
    res_new.affine_valid = sched.affine_valid;
    res_new.affine_bg    = sched.affine_bg;
    res_new.bitmap_valid = sched.bitmap_valid;
    res_new.dot_cycle    = sched.dot_cycle;
    res_new.line_end     = sched.line_end;
    if (sched.ref_valid) begin
      res_new.ref_x = line_x[sched.ref_id];
      res_new.ref_y = line_y[sched.ref_id];
    end
  end

  // output register with skid stage
  assign out_xfer = out_valid_q && result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_xfer) begin
        skid_valid_q <= 1'b0;
      end
    end else if (is_tick) begin
      if (out_valid_q && !out_xfer) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_q <= skid_q;
      end
    end else if (is_tick) begin
      if (out_valid_q && !out_xfer) begin
        skid_q <= res_new;
      end else begin
        out_q <= res_new;
      end
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.text_valid   = out_q.text_valid;
  assign result_o.text_bg      = out_q.text_bg;
  assign result_o.affine_valid = out_q.affine_valid;
  assign result_o.affine_bg    = out_q.affine_bg;
  assign result_o.bitmap_valid = out_q.bitmap_valid;
  assign result_o.dot_cycle    = out_q.dot_cycle;
  assign result_o.ref_x        = out_q.ref_x;
  assign result_o.ref_y        = out_q.ref_y;
  assign result_o.line_end     = out_q.line_end;

  // a tick transfer always leaves a result pending in the next cycle
  `SBFS_ASSERT_NXT(a_tick_gives_result, clk_i, rst_ni, is_tick, out_valid_q, "tick result lost")
  // the skid stage only fills behind a held output register
  `SBFS_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q, "skid without output")
  // line end is reported on the last dot cycle only
  `SBFS_ASSERT_IMP(a_line_end_cycle, clk_i, rst_ni, out_valid_q && out_q.line_end,
    out_q.dot_cycle == CYCLE_W'(LINE_CYCLES), "line end on wrong cycle")
  // affine and bitmap fetches exclude each other
  `SBFS_ASSERT_IMP(a_affine_or_bitmap, clk_i, rst_ni, out_valid_q && out_q.affine_valid,
    !out_q.bitmap_valid, "affine and bitmap in one cycle")

endmodule

// File: sv/sbfs_dot_sched.sv
// dot-cycle counter, mosaic counter and per-tick layer decode
// depends on sbfs_pkg
module sbfs_dot_sched #(
  parameter int LINE_CYCLES   = 1232,
  parameter int ACTIVE_CYCLES = 1007
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tick_i,
  input  logic                            line_start_i,
  input  logic [sbfs_pkg::LINE_W-1:0]     line_number_i,
  input  sbfs_pkg::sbfs_cfg_t             cfg_i,
  output sbfs_pkg::sbfs_sched_t           sched_o,
  output sbfs_pkg::sbfs_ref_ctl_t         ref_ctl_o
);
  import sbfs_pkg::*;

  logic [CYCLE_W-1:0]  cycle_q, cycle_d;
  logic [LINE_W-1:0]   line_q, line_d;
  logic [MOSAIC_W-1:0] mosaic_q, mosaic_d;

  logic [CYCLE_W-1:0]  cycle;
  logic                running, active, last;
  logic [MSIZE_W-1:0]  mosaic_inc;
  logic [MOSAIC_W-1:0] mosaic_next;
  logic [1:0]          text_id;
  logic                aff_id;
  logic                bitmap_mode;
  logic                adv_bg2, adv_bg3;

  assign cycle   = cycle_q + CYCLE_W'(1);
  assign running = cycle_q < CYCLE_W'(LINE_CYCLES);
  assign active  = cycle < CYCLE_W'(ACTIVE_CYCLES);
  assign last    = cycle == CYCLE_W'(LINE_CYCLES);
  assign text_id = cycle[1:0];
  assign aff_id  = ~cycle[1];
  assign bitmap_mode = cfg_i.bg_mode inside {[MODE_BITMAP_FIRST:MODE_BITMAP_LAST]};

  // vertical mosaic counter value after the line ends
  always_comb begin
    mosaic_inc = {1'b0, mosaic_q} + MSIZE_W'(1);
    if (line_q < MOSAIC_LAST_LINE) begin
      mosaic_next = (mosaic_inc == cfg_i.mosaic_size_y) ? '0 : mosaic_inc[MOSAIC_W-1:0];
    end else begin
      mosaic_next = '0;
    end
  end

  // layer decode for the cycle handled by this tick
  always_comb begin
    sched_o = '0;
    if (running) begin
      sched_o.dot_cycle = cycle;
      sched_o.line_end  = last;
      if ((cfg_i.bg_mode == MODE_TEXT || cfg_i.bg_mode == MODE_MIXED) &&
          (!text_id[1] || cfg_i.bg_mode == MODE_TEXT) && cfg_i.enable_mask[text_id]) begin
        sched_o.text_valid = 1'b1;
        sched_o.text_bg    = text_id;
      end
      if (active) begin
        if ((cfg_i.bg_mode == MODE_MIXED || cfg_i.bg_mode == MODE_AFFINE) &&
            (!aff_id || cfg_i.bg_mode == MODE_AFFINE) && cfg_i.enable_mask[{1'b1, aff_id}]) begin
          sched_o.affine_valid = 1'b1;
          sched_o.affine_bg    = aff_id;
          sched_o.ref_valid    = 1'b1;
          sched_o.ref_id       = aff_id;
        end
        if (bitmap_mode && cfg_i.enable_mask[2]) begin
          sched_o.bitmap_valid = 1'b1;
          sched_o.ref_valid    = 1'b1;
          sched_o.ref_id       = 1'b0;
        end
      end
    end
  end

  // reference advance at line end, gated by mosaic block boundary
  assign adv_bg2 = (cfg_i.bg_mode >= MODE_MIXED) && (cfg_i.bg_mode <= MODE_BITMAP_LAST) &&
                   cfg_i.enable_mask[2] &&
                   (!cfg_i.mosaic_enable_mask[0] || mosaic_next == '0);
  assign adv_bg3 = (cfg_i.bg_mode == MODE_AFFINE) && cfg_i.enable_mask[3] &&
                   (!cfg_i.mosaic_enable_mask[1] || mosaic_next == '0);

  always_comb begin
    ref_ctl_o            = '0;
    ref_ctl_o.line_start = line_start_i;
    ref_ctl_o.first_line = line_number_i == '0;
    ref_ctl_o.use_mosaic = cfg_i.mosaic_enable_mask;
    if (tick_i && running && last) begin
      ref_ctl_o.advance = {adv_bg3, adv_bg2};
    end
  end

  // counter next state
  always_comb begin
    cycle_d  = cycle_q;
    line_d   = line_q;
    mosaic_d = mosaic_q;
    if (line_start_i) begin
      cycle_d = '0;
      line_d  = line_number_i;
    end else if (tick_i && running) begin
      cycle_d = cycle;
      if (last) begin
        mosaic_d = mosaic_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q  <= '0;
      line_q   <= '0;
      mosaic_q <= '0;
    end else begin
      cycle_q  <= cycle_d;
      line_q   <= line_d;
      mosaic_q <= mosaic_d;
    end
  end

endmodule

// File: sv/sbfs_ref_unit.sv
// affine reference points of BG2/BG3: initial, current and line-latched values
// depends on sbfs_pkg
module sbfs_ref_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic                                 wr_bg_i,
  input  logic                                 wr_axis_i,
  input  logic signed [sbfs_pkg::REF_IN_W-1:0] wr_value_i,
  input  sbfs_pkg::sbfs_ref_ctl_t              ctl_i,
  input  sbfs_pkg::sbfs_cfg_t                  cfg_i,
  output logic signed [sbfs_pkg::REF_W-1:0]    line_x_o [2],
  output logic signed [sbfs_pkg::REF_W-1:0]    line_y_o [2]
);
  import sbfs_pkg::*;

  logic signed [REF_IN_W-1:0] init_x_q [2];
  logic signed [REF_IN_W-1:0] init_y_q [2];
  logic signed [REF_W-1:0]    cur_x_q  [2];
  logic signed [REF_W-1:0]    cur_y_q  [2];
  logic signed [REF_W-1:0]    line_x_q [2];
  logic signed [REF_W-1:0]    line_y_q [2];
  logic [3:0]                 written_q;

  logic signed [STEP_W-1:0]   step_b [2];
  logic signed [STEP_W-1:0]   step_d [2];
  logic signed [PROD_W-1:0]   prod_b [2];
  logic signed [PROD_W-1:0]   prod_d [2];
  logic signed [REF_W-1:0]    inc_x  [2];
  logic signed [REF_W-1:0]    inc_y  [2];
  logic signed [REF_W-1:0]    load_x [2];
  logic signed [REF_W-1:0]    load_y [2];

  assign step_b[0] = cfg_i.step_b_bg2;
  assign step_d[0] = cfg_i.step_d_bg2;
  assign step_b[1] = cfg_i.step_b_bg3;
  assign step_d[1] = cfg_i.step_d_bg3;

  // per-line increment, scaled by the mosaic height when mosaic is on
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod_b[i] = $signed({1'b0, cfg_i.mosaic_size_y}) * step_b[i];
      prod_d[i] = $signed({1'b0, cfg_i.mosaic_size_y}) * step_d[i];
      inc_x[i]  = ctl_i.use_mosaic[i] ? REF_W'(prod_b[i]) : REF_W'(step_b[i]);
      inc_y[i]  = ctl_i.use_mosaic[i] ? REF_W'(prod_d[i]) : REF_W'(step_d[i]);
      load_x[i] = (written_q[2*i] || ctl_i.first_line) ? REF_W'(init_x_q[i]) : cur_x_q[i];
      load_y[i] = (written_q[2*i+1] || ctl_i.first_line) ? REF_W'(init_y_q[i]) : cur_y_q[i];
    end
  end

  // reference writes, line-start reload and latch, line-end advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      for (int i = 0; i < 2; i++) begin
        init_x_q[i] <= '0;
        init_y_q[i] <= '0;
        cur_x_q[i]  <= '0;
        cur_y_q[i]  <= '0;
        line_x_q[i] <= '0;
        line_y_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      if (wr_axis_i) begin
        init_y_q[wr_bg_i] <= wr_value_i;
      end else begin
        init_x_q[wr_bg_i] <= wr_value_i;
      end
      written_q[{wr_bg_i, wr_axis_i}] <= 1'b1;
    end else if (ctl_i.line_start) begin
      written_q <= '0;
      for (int i = 0; i < 2; i++) begin
        cur_x_q[i]  <= load_x[i];
        cur_y_q[i]  <= load_y[i];
        line_x_q[i] <= load_x[i];
        line_y_q[i] <= load_y[i];
      end
    end else begin
      for (int i = 0; i < 2; i++) begin
        if (ctl_i.advance[i]) begin
          cur_x_q[i] <= cur_x_q[i] + inc_x[i];
          cur_y_q[i] <= cur_y_q[i] + inc_y[i];
        end
      end
    end
  end

  assign line_x_o = line_x_q;
  assign line_y_o = line_y_q;

endmodule
